FILE: hw/rtl/page_framebuffer_draw_engine_macros.svh
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_macros.svh
// assertion shorthands for the draw engine, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// same-cycle implication
`define PFDE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFDE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// shared constants for the page framebuffer draw engine
// ----------------------------------------------------------------------------
package pfde_pkg;

  // default panel geometry
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;

  // port widths
  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 7;

  // command codes
  localparam logic [2:0] REQ_PIXEL  = 3'd0;
  localparam logic [2:0] REQ_FILL   = 3'd1;
  localparam logic [2:0] REQ_SPAN   = 3'd2;
  localparam logic [2:0] REQ_GLYPH  = 3'd3;
  localparam logic [2:0] REQ_CURSOR = 3'd4;
  localparam logic [2:0] REQ_READ   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_INVERT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_W = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_H = 2'd2;

  // configuration reset values
  localparam logic [4:0] GLYPH_W_RST = 5'd7;
  localparam logic [6:0] GLYPH_H_RST = 7'd10;

endpackage

FILE: hw/rtl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// monochrome page-layout framebuffer with pixel, fill, span, glyph, cursor and read
// ----------------------------------------------------------------------------
// One command is taken at a time and returns one result transfer. The frame
// lives in a single-port synchronous byte memory of SCREEN_WIDTH *
// ceil(SCREEN_HEIGHT/8) entries. Every pixel of a pixel, span or glyph
// command is a read-modify-write of one byte through that port, column by
// column; a fill writes whole bytes through it, one store byte a cycle.
// After reset the same port clears the store, one byte a cycle, and no
// command is taken until it is done; configuration writes are taken at any
// time. A finished result sits in an output register, so the next command
// can start while it waits.
// ----------------------------------------------------------------------------
`include "page_framebuffer_draw_engine_macros.svh"

module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = pfde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pfde_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // command stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // x_pos[7:0], y_pos[15:8], color[16], pattern[32:17], span_len[37:33],
  // glyph_row[43:38], zero fill[47:44]
  input  logic [pfde_pkg::S_TDATA_W-1:0]      s_tdata,
  // req_type[2:0]
  input  logic [pfde_pkg::S_TUSER_W-1:0]      s_tuser,
  // last_row
  input  logic                                s_tlast,
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // read_data[7:0], accepted[8], zero fill[15:9]
  output logic [pfde_pkg::M_TDATA_W-1:0]      m_tdata,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [pfde_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pfde_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import pfde_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);

  localparam logic [8:0]    WIDTH_9   = 9'(SCREEN_WIDTH);
  localparam logic [8:0]    HEIGHT_9  = 9'(SCREEN_HEIGHT);
  localparam logic [8:0]    PAGES_9   = 9'(PAGE_COUNT);
  localparam logic [15:0]   WIDTH_16  = 16'(SCREEN_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_FILL,
    S_RDB,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic       invert_colors;
  logic [4:0] glyph_width;
  logic [6:0] glyph_height;

  // text cursor
  logic [7:0] cursor_x;
  logic [7:0] cursor_y;

  // per-command working registers
  logic [8:0]    xcol;
  logic [AW-1:0] row_base;
  logic          y_ok;
  logic [2:0]    bit_sel;
  logic [15:0]   pat_sh;
  logic [4:0]    cnt;
  logic          opaque;
  logic          ink;
  logic          res_acc;
  logic          is_read;
  logic          send_res;
  logic [7:0]    fill_byte;
  logic [AW-1:0] fill_idx;

  // result register
  logic [7:0] out_data;
  logic       out_acc;

  // frame memory
  logic [7:0]    frame_store [STORE_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;

  // command fields
  logic [2:0]  in_req;
  logic [7:0]  in_x;
  logic [7:0]  in_y;
  logic        in_color;
  logic [15:0] in_pat;
  logic [4:0]  in_len;
  logic [5:0]  in_grow;
  logic        in_last;

  assign in_req   = s_tuser[2:0];
  assign in_x     = s_tdata[7:0];
  assign in_y     = s_tdata[15:8];
  assign in_color = s_tdata[16];
  assign in_pat   = s_tdata[32:17];
  assign in_len   = s_tdata[37:33];
  assign in_grow  = s_tdata[43:38];
  assign in_last  = s_tlast;

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // clamped glyph size, fit check and target row
  logic [4:0]  gw_eff;
  logic [6:0]  gh_eff;
  logic [8:0]  glyph_y;
  logic        glyph_fit;
  logic [4:0]  span_n;

  always_comb begin
    gw_eff = glyph_width;
    if (glyph_width == 5'd0) begin
      gw_eff = 5'd1;
    end else if (glyph_width > 5'd16) begin
      gw_eff = 5'd16;
    end
    gh_eff = glyph_height;
    if (glyph_height == 7'd0) begin
      gh_eff = 7'd1;
    end else if (glyph_height > 7'd64) begin
      gh_eff = 7'd64;
    end
    glyph_y   = {1'b0, cursor_y} + {3'b000, in_grow};
    glyph_fit = (({1'b0, cursor_x} + {4'b0000, gw_eff}) < WIDTH_9) &&
                (({1'b0, cursor_y} + {2'b00, gh_eff}) < HEIGHT_9);
    span_n    = (in_len > 5'd16) ? 5'd16 : in_len;
  end

  // page row start for the incoming command
  logic [7:0]  page_sel;
  logic [15:0] page_prod;

  always_comb begin
    case (in_req)
      REQ_GLYPH: page_sel = {2'b00, glyph_y[8:3]};
      REQ_READ:  page_sel = in_y;
      default:   page_sel = {3'b000, in_y[7:3]};
    endcase
    page_prod = {8'h00, page_sel} * WIDTH_16;
  end

  // byte modify for the current column
  logic [7:0] bit_mask;
  logic       col_on;
  logic       col_white;
  logic       col_write;

  always_comb begin
    bit_mask  = 8'h01 << bit_sel;
    col_on    = pat_sh[15];
    col_write = y_ok && (xcol < WIDTH_9) && (opaque || col_on);
    col_white = (opaque ? (col_on ? ink : !ink) : 1'b1) ^ invert_colors;
  end

  // memory port control
  always_comb begin
    if (state == S_FILL) begin
      mem_addr  = fill_idx;
      mem_we    = 1'b1;
      mem_wdata = fill_byte;
    end else begin
      mem_addr  = row_base + AW'(xcol);
      mem_we    = (state == S_WR) && col_write;
      mem_wdata = col_white ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    end
  end

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_addr] <= mem_wdata;
    end
    rd_data <= frame_store[mem_addr];
  end

  // command sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_FILL;
      invert_colors <= 1'b0;
      glyph_width   <= GLYPH_W_RST;
      glyph_height  <= GLYPH_H_RST;
      cursor_x      <= 8'd0;
      cursor_y      <= 8'd0;
      fill_idx      <= '0;
      fill_byte     <= 8'h00;
      send_res      <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          CFG_INVERT:  invert_colors <= cfg_wdata[0];
          CFG_GLYPH_W: glyph_width   <= cfg_wdata[4:0];
          CFG_GLYPH_H: glyph_height  <= cfg_wdata[6:0];
          default:     ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            xcol     <= {1'b0, in_x};
            row_base <= page_prod[AW-1:0];
            y_ok     <= ({1'b0, in_y} < HEIGHT_9);
            bit_sel  <= in_y[2:0];
            pat_sh   <= in_pat;
            opaque   <= 1'b0;
            ink      <= in_color;
            res_acc  <= 1'b1;
            is_read  <= 1'b0;
            case (in_req)
              REQ_PIXEL: begin
                pat_sh <= 16'h8000;
                opaque <= 1'b1;
                cnt    <= 5'd1;
                state  <= S_RD;
              end
              REQ_FILL: begin
                fill_byte <= in_color ? 8'hFF : 8'h00;
                fill_idx  <= '0;
                send_res  <= 1'b1;
                state     <= S_FILL;
              end
              REQ_SPAN: begin
                cnt   <= span_n;
                state <= (span_n == 5'd0) ? S_DONE : S_RD;
              end
              REQ_GLYPH: begin
                xcol    <= {1'b0, cursor_x};
                y_ok    <= (glyph_y < HEIGHT_9);
                bit_sel <= glyph_y[2:0];
                opaque  <= 1'b1;
                cnt     <= gw_eff;
                if (glyph_fit) begin
                  if (in_last) begin
                    cursor_x <= cursor_x + {3'b000, gw_eff};
                  end
                  state <= S_RD;
                end else begin
                  res_acc <= 1'b0;
                  state   <= S_DONE;
                end
              end
              REQ_CURSOR: begin
                cursor_x <= in_x;
                cursor_y <= in_y;
                state    <= S_DONE;
              end
              REQ_READ: begin
                if (({1'b0, in_x} < WIDTH_9) && ({1'b0, in_y} < PAGES_9)) begin
                  is_read <= 1'b1;
                  state   <= S_RDB;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end

        // byte read issued, data lands in rd_data
        S_RD: begin
          state <= S_WR;
        end

        // write back the modified byte, step to the next column
        S_WR: begin
          xcol   <= xcol + 9'd1;
          pat_sh <= {pat_sh[14:0], 1'b0};
          cnt    <= cnt - 5'd1;
          state  <= (cnt == 5'd1) ? S_DONE : S_RD;
        end

        // sweep the whole store, also used as the clearing pass after reset
        S_FILL: begin
          fill_idx <= fill_idx + AW'(1);
          if (fill_idx == LAST_ADDR) begin
            state <= send_res ? S_DONE : S_IDLE;
          end
        end

        // read byte in flight
        S_RDB: begin
          state <= S_DONE;
        end

        // load the result register once it is free
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            out_data <= is_read ? rd_data : 8'h00;
            out_acc  <= res_acc;
            send_res <= 1'b0;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {7'b0000000, out_acc, out_data};

  // checks
  `PFDE_ASSERT_NXT(a_one_at_a_time, accept, !s_tready,
    "draw engine took a command while another was in flight")
  `PFDE_ASSERT_IMP(a_we_state, mem_we, (state == S_WR) || (state == S_FILL),
    "frame memory written outside a write or fill cycle")
  `PFDE_ASSERT_IMP(a_we_range, mem_we, mem_addr <= LAST_ADDR,
    "frame memory write beyond the store")
  `PFDE_ASSERT_NXT(a_cursor_hold, !accept, $stable(cursor_x) && $stable(cursor_y),
    "cursor moved without a command transfer")

endmodule
